>>> hdl/lbc_pkg.sv
// Shared types, register map and codeword functions for the (8,4) block codec.
`default_nettype none
package lbc_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned NibW     = 4;
  localparam int unsigned NumRows  = 4;
  localparam int unsigned MaxUnits = 5;
  localparam int unsigned PaddrW   = 5;
  localparam int unsigned PdataW   = 32;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_ROW0 = 3'd1,
    REG_ROW1 = 3'd2,
    REG_ROW2 = 3'd3,
    REG_ROW3 = 3'd4
  } reg_idx_e;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_e;

  // Row r of the generator matrix; bit 7 of each row is column 0.
  typedef logic [NumRows-1:0][DataW-1:0] gen_rows_t;

  // Codeword bit k is the parity of column k ANDed with the nibble.
  function automatic logic [DataW-1:0] encode_nibble(gen_rows_t rows, logic [NibW-1:0] nib);
    logic [DataW-1:0] cw;
    cw = '0;
    for (int r = 0; r < NumRows; r++) begin
      if (nib[NumRows-1-r]) begin
        cw = cw ^ rows[r];
      end
    end
    return cw;
  endfunction

  // Per-row extraction mask: the last unit column of that row found before
  // the scan has seen five unit columns, or zero if the row has none.
  function automatic gen_rows_t extract_masks(gen_rows_t rows);
    gen_rows_t        ext;
    logic [2:0]       found;
    logic [2:0]       ones;
    logic [1:0]       who;
    logic [DataW-1:0] colbit;
    ext   = '0;
    found = '0;
    for (int c = 0; c < DataW; c++) begin
      colbit = 8'h80 >> c;
      ones   = '0;
      who    = '0;
      for (int r = 0; r < NumRows; r++) begin
        if (|(rows[r] & colbit)) begin
          ones = ones + 3'd1;
          who  = 2'(r);
        end
      end
      if (found != 3'(MaxUnits) && ones == 3'd1) begin
        ext[who] = colbit;
        found    = found + 3'd1;
      end
    end
    return ext;
  endfunction

  function automatic logic [NibW-1:0] extract_nibble(gen_rows_t ext, logic [DataW-1:0] cw);
    logic [NibW-1:0] nib;
    nib = '0;
    for (int r = 0; r < NumRows; r++) begin
      nib[NumRows-1-r] = |(cw & ext[r]);
    end
    return nib;
  endfunction

endpackage
`default_nettype wire

>>> hdl/linear_block_codec_4_to_8.sv
// Top level of the (8,4) linear block codec with input and result registers.
//
// Encode mode turns every input byte into two codewords (high nibble first, tlast
// on the second); the single result register delivers one codeword per cycle
// unless the result stream stalls, and decode mode likewise takes one byte per
// cycle; the first byte of a pair yields no transfer and the second yields the
// data byte with tlast set. The input register accepts a new byte while a finished
// result still waits in the result register. The user must write configuration
// over the APB port only while idle, which is not enforced; pready is always high.
`default_nettype none
module linear_block_codec_4_to_8 (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // APB configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lbc_pkg::PaddrW-1:0]  paddr,
  input  wire logic [lbc_pkg::PdataW-1:0]  pwdata,
  output logic      [lbc_pkg::PdataW-1:0]  prdata,
  output logic                             pready,
  // Input stream
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [lbc_pkg::DataW-1:0]   s_axis_tdata,  // [7:0] data_byte
  // Result stream
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic      [lbc_pkg::DataW-1:0]   m_axis_tdata,  // [7:0] out_byte
  output logic                             m_axis_tlast
);
  import lbc_pkg::*;

  // Configuration registers
  mode_e     mode_q;
  gen_rows_t rows_q;
  reg_idx_e  cfg_idx;
  logic      cfg_wr;

  // Input register and sequencing state
  logic             in_valid_q;
  logic [DataW-1:0] in_byte_q;
  logic             sub_q;
  logic             phase_q;
  logic [NibW-1:0]  held_q;

  // Result register
  logic             out_valid_q;
  logic [DataW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;

  gen_rows_t        ext;
  logic [NibW-1:0]  ext_nib;
  logic             out_free;
  logic             gives_result;
  logic             out_load;
  logic             in_consume;
  logic             in_take;

  assign cfg_idx = reg_idx_e'(paddr[PaddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_ENCODE;
      rows_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE: mode_q    <= mode_e'(pwdata[0]);
        REG_ROW0: rows_q[0] <= pwdata[DataW-1:0];
        REG_ROW1: rows_q[1] <= pwdata[DataW-1:0];
        REG_ROW2: rows_q[2] <= pwdata[DataW-1:0];
        REG_ROW3: rows_q[3] <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_MODE: prdata[0]         = mode_q;
      REG_ROW0: prdata[DataW-1:0] = rows_q[0];
      REG_ROW1: prdata[DataW-1:0] = rows_q[1];
      REG_ROW2: prdata[DataW-1:0] = rows_q[2];
      REG_ROW3: prdata[DataW-1:0] = rows_q[3];
      default:  prdata = '0;
    endcase
  end

  assign ext     = extract_masks(rows_q);
  assign ext_nib = extract_nibble(ext, in_byte_q);

  // The first byte of a decode pair leaves the input register without a result.
  assign gives_result = (mode_q == MODE_ENCODE) || phase_q;
  assign out_free     = !out_valid_q || m_axis_tready;
  assign out_load     = in_valid_q && gives_result && out_free;
  assign in_consume   = in_valid_q &&
                        (!gives_result || (out_free && (mode_q == MODE_DECODE || sub_q)));
  assign s_axis_tready = !in_valid_q || in_consume;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (mode_q == MODE_ENCODE) begin
      out_byte_d = sub_q ? encode_nibble(rows_q, in_byte_q[NibW-1:0])
                         : encode_nibble(rows_q, in_byte_q[DataW-1:NibW]);
      out_last_d = sub_q;
    end else begin
      out_byte_d = {held_q, ext_nib};
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      sub_q       <= 1'b0;
      phase_q     <= 1'b0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (in_consume) begin
        in_valid_q <= 1'b0;
      end
      if (in_consume) begin
        sub_q <= 1'b0;
      end else if (out_load && mode_q == MODE_ENCODE) begin
        sub_q <= 1'b1;
      end
      if (in_consume && mode_q == MODE_DECODE) begin
        phase_q <= !phase_q;
        if (!phase_q) begin
          held_q <= ext_nib;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata;
    end
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  // A high-nibble codeword in the result register means its low half is still due.
  a_first_half_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> in_valid_q && sub_q)
    else $error("first codeword shown without its item in the input register");

  a_sub_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> in_valid_q)
    else $error("second-codeword flag set with an empty input register");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q)
    else $error("input stalled while the input register is empty");

  a_pair_phase_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_consume && mode_q == MODE_DECODE && !phase_q |=> phase_q)
    else $error("first byte of a pair did not advance the pair phase");

endmodule
`default_nettype wire

>>> verif/lbc_tb_pkg.sv
// Scoreboard class for the (8,4) block codec testbench: codec state and awaited result beats.
package lbc_tb_pkg;
  import lbc_pkg::*;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             tail;
  } codec_beat_t;

  class codeword_scoreboard;
    mode_e            mode;
    logic [DataW-1:0] rows [NumRows];
    logic             pair_open;
    logic [NibW-1:0]  held_nib;
    codec_beat_t      awaited_beats [$];
    int unsigned      errors;

    function new();
      mode      = MODE_ENCODE;
      foreach (rows[r]) rows[r] = '0;
      pair_open = 1'b0;
      held_nib  = '0;
      errors    = 0;
    endfunction

    // Indexes past the last row register are ignored, as the block does.
    function void write_reg(int unsigned idx, logic [31:0] value);
      if (idx == REG_MODE) begin
        mode = mode_e'(value[0]);
      end else if (idx <= REG_ROW3) begin
        rows[idx - REG_ROW0] = value[DataW-1:0];
      end
    endfunction

    function logic [31:0] read_reg(int unsigned idx);
      if (idx == REG_MODE) begin
        return {31'b0, mode};
      end
      return {24'b0, rows[idx - REG_ROW0]};
    endfunction

    function logic [DataW-1:0] codeword(logic [NibW-1:0] nib);
      logic [DataW-1:0] cw;
      cw = '0;
      for (int r = 0; r < NumRows; r++) begin
        if (nib[NumRows-1-r]) begin
          cw = cw ^ rows[r];
        end
      end
      return cw;
    endfunction

    // Each row reads its bit from the last column, scanning from bit 7 down, in which
    // it is the only set bit; the scan gives up after five such columns.
    function logic [NibW-1:0] recover_nibble(logic [DataW-1:0] cw);
      logic [DataW-1:0] taps [NumRows];
      logic [NibW-1:0]  nib;
      int               found;
      int               hits;
      int               owner;
      foreach (taps[r]) taps[r] = '0;
      nib   = '0;
      found = 0;
      for (int bitpos = DataW - 1; bitpos >= 0 && found < int'(MaxUnits); bitpos--) begin
        hits  = 0;
        owner = 0;
        for (int r = 0; r < NumRows; r++) begin
          if (rows[r][bitpos]) begin
            hits++;
            owner = r;
          end
        end
        if (hits == 1) begin
          taps[owner]         = '0;
          taps[owner][bitpos] = 1'b1;
          found++;
        end
      end
      for (int r = 0; r < NumRows; r++) begin
        nib[NumRows-1-r] = |(cw & taps[r]);
      end
      return nib;
    endfunction

    function void note_input(logic [DataW-1:0] b);
      codec_beat_t beat;
      if (mode == MODE_ENCODE) begin
        beat.value = codeword(b[7:4]);
        beat.tail  = 1'b0;
        awaited_beats.push_back(beat);
        beat.value = codeword(b[3:0]);
        beat.tail  = 1'b1;
        awaited_beats.push_back(beat);
      end else if (!pair_open) begin
        held_nib  = recover_nibble(b);
        pair_open = 1'b1;
      end else begin
        beat.value = {held_nib, recover_nibble(b)};
        beat.tail  = 1'b1;
        awaited_beats.push_back(beat);
        pair_open  = 1'b0;
      end
    endfunction

    function void check_result(logic [DataW-1:0] value, logic tail);
      codec_beat_t want;
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual out_byte %02h last %0b",
                 $time, value, tail);
        errors++;
        return;
      end
      want = awaited_beats.pop_front();
      if (value !== want.value) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
        errors++;
      end
      if (tail !== want.tail) begin
        $display("%0t: last expected %0b actual %0b", $time, want.tail, tail);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_beats.size();
    endfunction
  endclass

endpackage

>>> verif/linear_block_codec_4_to_8_tb.sv
// Self-checking testbench for the (8,4) linear block codec with random stalls on both streams.
module linear_block_codec_4_to_8_tb;
  import lbc_pkg::*;
  import lbc_tb_pkg::*;

  localparam int unsigned HalfPeriod   = 6;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainLimit   = 4000;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhaseItems   = 110;
  localparam int unsigned HoldPhase    = 2;
  localparam longint     TimeoutUnits  = 3_600_000;
  localparam logic [2:0] REG_SPARE_LO  = 3'd5;
  localparam logic [2:0] REG_SPARE_HI  = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [PdataW-1:0]   pwdata;
  logic [PdataW-1:0]   prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [DataW-1:0]    s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [DataW-1:0]    m_axis_tdata;
  logic                m_axis_tlast;

  codeword_scoreboard codec_sb;
  logic               quiet;
  logic               hold_req;

  always #HalfPeriod clk_i = ~clk_i;

  linear_block_codec_4_to_8 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  task automatic send_byte(input logic [DataW-1:0] b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    codec_sb.note_input(b);
  endtask

  // The bus returns to idle after each access, so back-to-back accesses never
  // drive the select twice at the same edge.
  task automatic apb_access(input logic write, input logic [2:0] idx,
                            input logic [PdataW-1:0] wdata, output logic [PdataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [PdataW-1:0] value);
    logic [PdataW-1:0] unused;
    apb_access(1'b1, idx, value, unused);
    codec_sb.write_reg(idx, value);
  endtask

  task automatic readback_all();
    logic [PdataW-1:0] got;
    for (int idx = REG_MODE; idx <= REG_ROW3; idx++) begin
      apb_access(1'b0, 3'(idx), $urandom(), got);
      if (got !== codec_sb.read_reg(idx)) begin
        $display("%0t: register %0d expected %08h actual %08h",
                 $time, idx, codec_sb.read_reg(idx), got);
        codec_sb.errors++;
      end
    end
  endtask

  // The upper bits of each write are random, so only the register width is kept.
  task automatic set_matrix(input logic [DataW-1:0] r0, r1, r2, r3);
    write_reg(REG_ROW0, ($urandom() & 32'hFFFF_FF00) | r0);
    write_reg(REG_ROW1, ($urandom() & 32'hFFFF_FF00) | r1);
    write_reg(REG_ROW2, ($urandom() & 32'hFFFF_FF00) | r2);
    write_reg(REG_ROW3, ($urandom() & 32'hFFFF_FF00) | r3);
  endtask

  task automatic set_mode(input mode_e m);
    write_reg(REG_MODE, ($urandom() & 32'hFFFF_FFFE) | m);
  endtask

  // A first byte of a decode pair yields nothing, so settle past the last result.
  task automatic wait_drained();
    int unsigned spin;
    s_axis_tvalid <= 1'b0;
    spin = 0;
    while (codec_sb.pending() != 0 && spin < DrainLimit) begin
      @(posedge clk_i);
      spin++;
    end
    if (codec_sb.pending() != 0) begin
      $display("%0t: %0d results expected but never delivered", $time, codec_sb.pending());
      codec_sb.errors++;
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_row(int unsigned r, logic systematic);
    if (systematic) begin
      return (8'h80 >> r) | 8'($urandom_range(0, 15));
    end
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80 >> $urandom_range(0, 7);
      default: return 8'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned n;
    logic        systematic;
    codec_sb = new();
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The matrix is all zero after reset, so every codeword is zero.
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();
    readback_all();

    set_matrix(8'h87, 8'h4B, 8'h2D, 8'h1E);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h0F);
    send_byte(8'hF0);
    wait_drained();
    set_mode(MODE_DECODE);
    send_byte(8'h87);
    send_byte(8'h4B);
    send_byte(8'hFF);
    send_byte(8'h00);

    // Half a pair, then an encode, then the pair is finished.
    send_byte(8'h2D);
    wait_drained();
    set_mode(MODE_ENCODE);
    send_byte(8'h3C);
    wait_drained();
    set_mode(MODE_DECODE);
    send_byte(8'h1E);

    // No column has a single set bit: every row reads zero.
    wait_drained();
    set_matrix(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);

    // Every column is a unit column: later finds win and the scan stops at five.
    wait_drained();
    set_matrix(8'hC0, 8'h30, 8'h0C, 8'h03);
    send_byte(8'h5A);
    send_byte(8'hFF);
    wait_drained();
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    readback_all();

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      systematic = 1'($urandom_range(0, 1));
      set_matrix(pick_row(0, systematic), pick_row(1, systematic),
                 pick_row(2, systematic), pick_row(3, systematic));
      set_mode(p == HoldPhase ? MODE_ENCODE : mode_e'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) begin
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom());
      end
      readback_all();
      quiet    = (p != HoldPhase) && ($urandom_range(0, 3) == 0);
      hold_req = (p == HoldPhase);
      // An odd count leaves a decode pair open across the next configuration change.
      n = PhaseItems + $urandom_range(0, 1);
      repeat (n) send_byte(8'($urandom()));
    end
    wait_drained();

    if (codec_sb.errors == 0) begin
      $display("linear_block_codec_4_to_8 verification clean");
    end else begin
      $display("linear_block_codec_4_to_8 verification failed");
    end
    $finish;
  end

  // Result side: random back-pressure, and one long hold-off that fills the block.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HoldCycles;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 9);
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      codec_sb.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    #TimeoutUnits;
    $display("linear_block_codec_4_to_8 verification failed");
    $finish;
  end

endmodule
